// ----- rtl/ilir_pkg.sv -----
// Package for the indexed list: sizes, operation and status codes, and the
// control word that the top level broadcasts to every list cell.
// No dependencies.
package ilir_pkg;

	localparam int DEPTH      = 16;
	localparam int ITEM_WIDTH = 32;

	// Widths of the fields of an item as they appear on the ports.
	localparam int OP_W      = 3;
	localparam int POS_W     = 5;
	localparam int VALUE_W   = 32;
	localparam int STATUS_W  = 2;
	localparam int TOTAL_W   = 5;

	// Count of entries, able to hold DEPTH itself.
	localparam int CNT_W = $clog2(DEPTH + 1);
	// Index of one cell.
	localparam int IDX_W = $clog2(DEPTH);
	// Width in which positions and counts are compared.
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 40;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_REMOVE = 3'd2,
		OP_READ   = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Shift command seen by all cells in the same cycle.
	typedef struct packed {
		logic                  ins;
		logic                  rem;
		logic [CNT_W-1:0]      pos;
		logic [ITEM_WIDTH-1:0] word;
	} cell_ctrl_t;

endpackage

// ----- rtl/ilir_cell.sv -----
// One list cell: holds the entry at its own index and, on an insert or a
// remove, takes the new word or the entry of its lower or upper neighbor.
// Depends on ilir_pkg.
module ilir_cell (
	input  logic                           clk,
	input  ilir_pkg::cell_ctrl_t           ctrl,
	input  logic [ilir_pkg::CNT_W-1:0]     index,
	input  logic [ilir_pkg::ITEM_WIDTH-1:0] left_data,
	input  logic [ilir_pkg::ITEM_WIDTH-1:0] right_data,
	output logic [ilir_pkg::ITEM_WIDTH-1:0] data_q
);

	logic [ilir_pkg::ITEM_WIDTH-1:0] data_d;

	always_comb begin
		data_d = data_q;
		if (ctrl.ins) begin
			if (index == ctrl.pos) begin
				data_d = ctrl.word;
			end else if (index > ctrl.pos) begin
				data_d = left_data;
			end
		end
		if (ctrl.rem) begin
			if (index >= ctrl.pos) begin
				data_d = right_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

// ----- rtl/indexed_list_insert_remove.sv -----
// Indexed list with insert and remove: top level with request decoding,
// the entry count, the row of list cells and the result register.
// Depends on ilir_pkg and ilir_cell.
//
// This block keeps an ordered list of up to DEPTH words in a row of cells,
// one cell per list position. Each request item asks for an append, an
// insert at a position, a remove at a position, a read at a position or a
// clear. An insert makes every cell above the position take the word of
// its lower neighbor, and a remove makes every cell at and above the
// position take the word of its upper neighbor, all cells in the same
// clock edge, so every operation completes in the cycle its item is
// accepted and the block sustains one item per clock while the result
// register is free. The result item appears in the output register on
// the next cycle, and a new request is taken while that result waits,
// as long as the result is leaving or the register is empty. A request
// that falls outside the list, or an append or insert on a full list,
// leaves the list as it is and reports its status. Stored words have no
// reset; only entries below the count are read, and reset clears the count.
module indexed_list_insert_remove (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// Fields from bit 0 up: position (5), item_value (32), zero fill (3).
	input  logic [39:0] s_tdata,
	// Fields from bit 0 up: operation (3).
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// Fields from bit 0 up: read_value (32), status (2), entry_total (5),
	// is_empty (1).
	output logic [39:0] m_tdata
);

	localparam int IW = ilir_pkg::ITEM_WIDTH;
	localparam int CW = ilir_pkg::CNT_W;

	// Handshake and result register.
	logic                              accept;
	logic                              out_valid_q;
	logic [ilir_pkg::OUT_DATA_W-1:0]   out_data_q;

	// Request fields.
	ilir_pkg::op_t                     op;
	logic [ilir_pkg::POS_W-1:0]        pos;
	logic [ilir_pkg::VALUE_W-1:0]      item_value;
	logic [IW+ilir_pkg::VALUE_W-1:0]   word_ext;
	logic [IW-1:0]                     word;

	// Count and comparisons against it.
	logic [CW-1:0]                     count_q;
	logic [CW-1:0]                     count_d;
	logic [ilir_pkg::CMP_W-1:0]        pos_ext;
	logic [ilir_pkg::CMP_W-1:0]        cnt_ext;
	logic                              full;

	// Result fields.
	ilir_pkg::status_t                 status;
	logic [IW-1:0]                     rd_word;
	logic [ilir_pkg::VALUE_W+IW-1:0]   rd_ext;
	logic [ilir_pkg::VALUE_W-1:0]      read_value;
	logic [ilir_pkg::TOTAL_W+CW-1:0]   total_ext;
	logic [ilir_pkg::TOTAL_W-1:0]      entry_total;
	logic                              is_empty;

	// Cell row.
	ilir_pkg::cell_ctrl_t              ctrl;
	logic [IW-1:0]                     cell_data [ilir_pkg::DEPTH];

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign op         = ilir_pkg::op_t'(s_tuser);
	assign pos        = s_tdata[4:0];
	assign item_value = s_tdata[36:5];

	// Only the low ITEM_WIDTH bits of the payload are stored.
	assign word_ext = {{IW{1'b0}}, item_value};
	assign word     = word_ext[IW-1:0];

	assign pos_ext = ilir_pkg::CMP_W'(pos);
	assign cnt_ext = ilir_pkg::CMP_W'(count_q);
	assign full    = (count_q == CW'(ilir_pkg::DEPTH));

	// Decode the request against the current count. An append is an insert
	// at the end of the list. The position is narrowed to the count width,
	// and the narrowed value is used only where it lies within the list.
	always_comb begin
		status    = ilir_pkg::ST_DONE;
		rd_word   = '0;
		count_d   = count_q;
		ctrl.ins  = 1'b0;
		ctrl.rem  = 1'b0;
		ctrl.pos  = pos_ext[CW-1:0];
		ctrl.word = word;
		case (op)
			ilir_pkg::OP_APPEND: begin
				ctrl.pos = count_q;
				if (full) begin
					status = ilir_pkg::ST_FULL;
				end else begin
					ctrl.ins = accept;
					count_d  = count_q + CW'(1);
				end
			end
			ilir_pkg::OP_INSERT: begin
				if (pos_ext > cnt_ext) begin
					status = ilir_pkg::ST_RANGE;
				end else if (full) begin
					status = ilir_pkg::ST_FULL;
				end else begin
					ctrl.ins = accept;
					count_d  = count_q + CW'(1);
				end
			end
			ilir_pkg::OP_REMOVE: begin
				if (pos_ext >= cnt_ext) begin
					status = ilir_pkg::ST_RANGE;
				end else begin
					ctrl.rem = accept;
					count_d  = count_q - CW'(1);
				end
			end
			ilir_pkg::OP_READ: begin
				if (pos_ext >= cnt_ext) begin
					status = ilir_pkg::ST_RANGE;
				end else begin
					rd_word = cell_data[pos_ext[ilir_pkg::IDX_W-1:0]];
				end
			end
			ilir_pkg::OP_CLEAR: begin
				count_d = '0;
			end
			default: begin
				// Unused operation codes leave everything as it is.
			end
		endcase
	end

	// The row of cells. The lowest cell has no lower neighbor and the
	// highest cell keeps its own word when the list closes up on a remove.
	for (genvar i = 0; i < ilir_pkg::DEPTH; i++) begin : g_cell
		logic [IW-1:0] left_data;
		logic [IW-1:0] right_data;

		if (i == 0) begin : g_first
			assign left_data = word;
		end else begin : g_inner_left
			assign left_data = cell_data[i-1];
		end

		if (i == ilir_pkg::DEPTH - 1) begin : g_last
			assign right_data = cell_data[i];
		end else begin : g_inner_right
			assign right_data = cell_data[i+1];
		end

		ilir_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.index      (CW'(i)),
			.left_data  (left_data),
			.right_data (right_data),
			.data_q     (cell_data[i])
		);
	end

	// Result fields reflect the count after the operation.
	assign rd_ext      = {{ilir_pkg::VALUE_W{1'b0}}, rd_word};
	assign read_value  = rd_ext[ilir_pkg::VALUE_W-1:0];
	assign total_ext   = {{ilir_pkg::TOTAL_W{1'b0}}, count_d};
	assign entry_total = total_ext[ilir_pkg::TOTAL_W-1:0];
	assign is_empty    = (count_d == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {is_empty, entry_total, status, read_value};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// The count never grows past the capacity of the cell row.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ilir_pkg::DEPTH))
		else $error("entry count exceeds list capacity");

	// An accepted clear empties the list.
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == ilir_pkg::OP_CLEAR) |=> (count_q == '0))
		else $error("clear did not empty the list");

	// An append on a list with room adds exactly one entry.
	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == ilir_pkg::OP_APPEND && !full)
		|=> (count_q == $past(count_q) + CW'(1)))
		else $error("append did not add one entry");

	// A remove within the list takes away exactly one entry.
	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == ilir_pkg::OP_REMOVE && pos_ext < cnt_ext)
		|=> (count_q == $past(count_q) - CW'(1)))
		else $error("remove did not take away one entry");

endmodule

// ----- tb/sv/indexed_list_insert_remove_tb.sv -----
// Testbench for indexed_list_insert_remove: directed and random list requests
// checked item by item against a behavioral model of the list kept here.
// Depends on ilir_pkg and the indexed_list_insert_remove RTL.
`timescale 1ns / 100ps

module indexed_list_insert_remove_tb;

	// A long run of cycles in which neither side moves an item means the
	// block has hung.
	localparam int STALL_LIMIT = 2000;
	// Cycles allowed after the last expected result for stray results.
	localparam int TAIL_CYCLES = 8;

	// One result item split into its fields.
	typedef struct {
		logic [ilir_pkg::VALUE_W-1:0] read_value;
		ilir_pkg::status_t            status;
		logic [ilir_pkg::TOTAL_W-1:0] entry_total;
		logic                         is_empty;
	} list_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// Fields from bit 0 up: position (5), item_value (32), zero fill (3).
	logic [39:0] s_tdata = '0;
	// Fields from bit 0 up: operation (3).
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// Fields from bit 0 up: read_value (32), status (2), entry_total (5),
	// is_empty (1).
	logic [39:0] m_tdata;

	// Behavioral copy of the list: stored words and the number of valid ones.
	logic [63:0]  list_words [ilir_pkg::DEPTH];
	int           list_len = 0;
	// Results predicted for accepted requests, oldest first.
	list_result_t pending_results [$];

	// Percent of cycles in which the sender and the receiver hold off.
	int src_idle_pct = 0;
	int dst_idle_pct = 0;
	int error_count = 0;
	int stall_cycles = 0;

	indexed_list_insert_remove uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one request to the model list and returns the result the block
	// must give for it. Only the low ITEM_WIDTH bits of a word are kept.
	function automatic list_result_t apply_request(logic [ilir_pkg::OP_W-1:0] op,
			logic [ilir_pkg::POS_W-1:0] pos, logic [ilir_pkg::VALUE_W-1:0] word);
		list_result_t res;
		logic [63:0]  kept;
		int           i;
		kept = {32'd0, word} & ((64'd1 << ilir_pkg::ITEM_WIDTH) - 64'd1);
		res.read_value = '0;
		res.status = ilir_pkg::ST_DONE;
		case (op)
			ilir_pkg::OP_APPEND: begin
				if (list_len >= ilir_pkg::DEPTH) begin
					res.status = ilir_pkg::ST_FULL;
				end else begin
					list_words[list_len] = kept;
					list_len++;
				end
			end
			ilir_pkg::OP_INSERT: begin
				// The range test wins over the full test.
				if (int'(pos) > list_len) begin
					res.status = ilir_pkg::ST_RANGE;
				end else if (list_len >= ilir_pkg::DEPTH) begin
					res.status = ilir_pkg::ST_FULL;
				end else begin
					for (i = list_len; i > int'(pos); i--)
						list_words[i] = list_words[i-1];
					list_words[pos] = kept;
					list_len++;
				end
			end
			ilir_pkg::OP_REMOVE: begin
				if (int'(pos) >= list_len) begin
					res.status = ilir_pkg::ST_RANGE;
				end else begin
					for (i = int'(pos); i + 1 < list_len; i++)
						list_words[i] = list_words[i+1];
					list_len--;
				end
			end
			ilir_pkg::OP_READ: begin
				if (int'(pos) >= list_len)
					res.status = ilir_pkg::ST_RANGE;
				else
					res.read_value = list_words[pos][ilir_pkg::VALUE_W-1:0];
			end
			ilir_pkg::OP_CLEAR: begin
				// The words stay in place but are no longer part of the list.
				list_len = 0;
			end
			default: begin
				// Codes past clear leave everything as it is.
			end
		endcase
		res.entry_total = list_len[ilir_pkg::TOTAL_W-1:0];
		res.is_empty = (list_len == 0);
		return res;
	endfunction

	// Prints one line per mismatch and counts every one.
	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t ERROR %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	// Offers one request item and waits until the block takes it. Valid stays
	// high between back-to-back items and is only lowered for an idle gap,
	// so it is never lowered and raised within the same edge. The model is
	// updated at the edge that accepts the item.
	task automatic send_request(logic [ilir_pkg::OP_W-1:0] op,
			logic [ilir_pkg::POS_W-1:0] pos, logic [ilir_pkg::VALUE_W-1:0] word);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, word, pos};
		s_tuser <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(apply_request(op, pos, word));
	endtask

	// Requests on an empty list: every position is out of range, the unused
	// codes do nothing, and a clear of an empty list is harmless.
	task automatic test_empty_list();
		int code;
		send_request(ilir_pkg::OP_READ, 5'd0, 32'h0);
		send_request(ilir_pkg::OP_REMOVE, 5'd0, 32'h0);
		send_request(ilir_pkg::OP_INSERT, 5'd1, 32'h1234_5678);
		send_request(ilir_pkg::OP_READ, 5'd31, 32'hFFFF_FFFF);
		send_request(ilir_pkg::OP_REMOVE, 5'd31, 32'hFFFF_FFFF);
		for (code = int'(ilir_pkg::OP_CLEAR) + 1; code < (1 << ilir_pkg::OP_W); code++)
			send_request(code[ilir_pkg::OP_W-1:0], 5'd31, 32'hFFFF_FFFF);
		send_request(ilir_pkg::OP_CLEAR, 5'd0, 32'h0);
	endtask

	// Insert at the front, in the middle and at the end, then reads of every
	// position and removes of the middle, the last and the first entry.
	task automatic test_edit_positions();
		int i;
		send_request(ilir_pkg::OP_INSERT, 5'd0, 32'h0000_0000);
		send_request(ilir_pkg::OP_APPEND, 5'd0, 32'hFFFF_FFFF);
		// A position equal to the count acts as an append.
		send_request(ilir_pkg::OP_INSERT, 5'd2, 32'hA5A5_A5A5);
		send_request(ilir_pkg::OP_INSERT, 5'd1, 32'h5A5A_5A5A);
		for (i = 0; i <= 4; i++)
			send_request(ilir_pkg::OP_READ, i[ilir_pkg::POS_W-1:0], 32'h0);
		send_request(ilir_pkg::OP_REMOVE, 5'd1, 32'h0);
		send_request(ilir_pkg::OP_REMOVE, 5'd2, 32'h0);
		send_request(ilir_pkg::OP_REMOVE, 5'd0, 32'h0);
		send_request(ilir_pkg::OP_READ, 5'd0, 32'h0);
	endtask

	// Fills the list and tries every way of growing a full list, including
	// an insert past the end, which reports a range error before fullness.
	task automatic test_full_list();
		while (list_len < ilir_pkg::DEPTH)
			send_request(ilir_pkg::OP_APPEND, 5'd0, $urandom);
		send_request(ilir_pkg::OP_APPEND, 5'd0, 32'hDEAD_0001);
		send_request(ilir_pkg::OP_INSERT, 5'd0, 32'hDEAD_0002);
		send_request(ilir_pkg::OP_INSERT, ilir_pkg::POS_W'(ilir_pkg::DEPTH), 32'hDEAD_0003);
		send_request(ilir_pkg::OP_INSERT, ilir_pkg::POS_W'(ilir_pkg::DEPTH + 1),
			32'hDEAD_0004);
		send_request(ilir_pkg::OP_READ, ilir_pkg::POS_W'(ilir_pkg::DEPTH - 1), 32'h0);
		send_request(ilir_pkg::OP_READ, ilir_pkg::POS_W'(ilir_pkg::DEPTH), 32'h0);
		send_request(ilir_pkg::OP_REMOVE, ilir_pkg::POS_W'(ilir_pkg::DEPTH - 1), 32'h0);
		send_request(ilir_pkg::OP_INSERT, 5'd5, 32'hFFFF_FFFF);
		send_request(ilir_pkg::OP_CLEAR, 5'd0, 32'h0);
		send_request(ilir_pkg::OP_READ, 5'd0, 32'h0);
	endtask

	// Random requests. Most use positions inside the list so that the shifts
	// are exercised; the rest use any position, codes past clear, or clears.
	// The mix of growing and shrinking requests changes every few dozen
	// items so that the list swings between empty and full.
	task automatic test_random_traffic(int num_items);
		int                           k;
		int                           r;
		int                           grow_pct;
		logic [ilir_pkg::OP_W-1:0]    op;
		logic [ilir_pkg::POS_W-1:0]   pos;
		logic [ilir_pkg::VALUE_W-1:0] word;
		grow_pct = 50;
		for (k = 0; k < num_items; k++) begin
			if (k % 32 == 0) begin
				r = $urandom_range(2);
				grow_pct = (r == 0) ? 20 : (r == 1) ? 50 : 85;
			end
			r = $urandom_range(99);
			if (r < 2) begin
				op = ilir_pkg::OP_CLEAR;
			end else if (r < 5) begin
				op = ilir_pkg::OP_W'($urandom_range((1 << ilir_pkg::OP_W) - 1,
					int'(ilir_pkg::OP_CLEAR) + 1));
			end else if ($urandom_range(99) < grow_pct) begin
				op = $urandom_range(1) ? ilir_pkg::OP_INSERT : ilir_pkg::OP_APPEND;
			end else begin
				op = $urandom_range(1) ? ilir_pkg::OP_REMOVE : ilir_pkg::OP_READ;
			end
			if ($urandom_range(99) < 20)
				pos = ilir_pkg::POS_W'($urandom_range((1 << ilir_pkg::POS_W) - 1));
			else if (op == ilir_pkg::OP_INSERT)
				pos = ilir_pkg::POS_W'($urandom_range(list_len));
			else
				pos = ilir_pkg::POS_W'($urandom_range((list_len > 0) ? list_len - 1 : 0));
			r = $urandom_range(9);
			word = (r == 0) ? '0 : (r == 1) ? '1 : ilir_pkg::VALUE_W'($urandom);
			send_request(op, pos, word);
		end
	endtask

	// Receiver: random back-pressure and the check of each result item
	// against the oldest prediction. Outputs are sampled at the edge, before
	// the block updates them, so the check sees the values being accepted.
	always @(posedge clk) begin : check_results
		list_result_t want;
		list_result_t got;
		m_tready <= ($urandom_range(99) >= dst_idle_pct);
		if (m_tvalid && m_tready) begin
			got.read_value = m_tdata[31:0];
			got.status = ilir_pkg::status_t'(m_tdata[33:32]);
			got.entry_total = m_tdata[38:34];
			got.is_empty = m_tdata[39];
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request pending", m_tdata, 64'd0);
			end else begin
				want = pending_results.pop_front();
				if (got.read_value !== want.read_value)
					report_mismatch("read_value", got.read_value, want.read_value);
				if (got.status !== want.status)
					report_mismatch("status", got.status, want.status);
				if (got.entry_total !== want.entry_total)
					report_mismatch("entry_total", got.entry_total, want.entry_total);
				if (got.is_empty !== want.is_empty)
					report_mismatch("is_empty", got.is_empty, want.is_empty);
			end
		end
	end

	// Watchdog: ends the run when no item moves on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("indexed_list_insert_remove_tb failed");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender mostly busy, receiver often stalling.
		src_idle_pct = 12;
		dst_idle_pct = 58;
		test_empty_list();
		test_edit_positions();
		test_full_list();
		test_random_traffic(480);

		// Sender often idle, receiver mostly ready.
		src_idle_pct = 58;
		dst_idle_pct = 12;
		test_random_traffic(480);

		// Full rate on both sides.
		src_idle_pct = 0;
		dst_idle_pct = 0;
		test_random_traffic(490);

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never delivered", pending_results.size(), 64'd0);

		if (error_count == 0)
			$display("indexed_list_insert_remove_tb passed");
		else
			$display("indexed_list_insert_remove_tb failed");
		$finish;
	end

endmodule
